>>> rtl/core/dpht_pkg.sv
// Shared types and constants for the depth-preferred hash table.
package dpht_pkg;

    localparam int KEY_W        = 64;
    localparam int EVAL_W       = 32;
    localparam int DEPTH_W      = 8;
    localparam int FLAG_W       = 8;
    localparam int SLOT_INDEX_W = 12;
    localparam int SLOT_W       = KEY_W + EVAL_W + DEPTH_W + FLAG_W;

    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [EVAL_W-1:0]  eval;
        logic [FLAG_W-1:0]         bound_flag;
    } t_in_item;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_INDEX_W-1:0]   slot_index;
        logic signed [EVAL_W-1:0]  found_eval;
        logic [DEPTH_W-1:0]        found_depth;
        logic [FLAG_W-1:0]         found_flag;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [EVAL_W-1:0]         eval;
        logic [DEPTH_W-1:0]        depth;
        logic [FLAG_W-1:0]         flag;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic hash;
        logic start;
        logic scan;
        logic write;
        logic emit;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic done;
        logic is_store;
        logic out_free;
    } t_dp_st;

endpackage

>>> rtl/core/dpht_ram.sv
// Generic simple dual-port RAM with registered read.
module dpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/dpht_ctrl.sv
// Controller state machine: sequences clear, hash, scan, write and emit.
module dpht_ctrl
    import dpht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_st  i_st,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_st.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (i_st.mod_done) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_st.done) n_state = i_st.is_store ? S_WRITE : S_EMIT;
            end
            S_WRITE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_HASH: begin
                o_cmd.hash  = 1'b1;
                o_cmd.start = i_st.mod_done;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_st.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/dpht_datapath.sv
// Datapath: slot memory, window scan, replacement choice and result register.
module dpht_datapath
    import dpht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int PROBE_WINDOW  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_st    o_st,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int OFF_W   = $clog2(PROBE_WINDOW + 1);
    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [OFF_W-1:0] LAST_OFF  = OFF_W'(PROBE_WINDOW - 1);
    localparam logic [OFF_W-1:0] WIN_OFF   = OFF_W'(PROBE_WINDOW);

    t_in_item          r_item;
    logic [IDX_W-1:0]  base_slot;
    logic              mod_done;

    logic [IDX_W-1:0]  r_rd_slot;
    logic [OFF_W-1:0]  r_issue_off;
    logic              r_chk_v;
    logic [IDX_W-1:0]  r_chk_slot;
    logic [OFF_W-1:0]  r_chk_off;
    logic [IDX_W-1:0]  r_worst_slot;
    logic [DEPTH_W-1:0] r_worst_depth;
    logic              r_hit;
    logic [IDX_W-1:0]  r_target;
    t_slot             r_fnd;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [IDX_W-1:0]  r_clr_addr;

    logic              issue;
    logic [SLOT_W-1:0] rd_data;
    t_slot             rd_slot;
    logic              key_match;
    logic              stop;
    logic              hit;
    logic              take_new_worst;
    logic [IDX_W-1:0]  n_worst_slot;
    logic [DEPTH_W-1:0] n_worst_depth;
    logic [IDX_W-1:0]  n_target;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    t_slot             wr_slot;
    logic [SLOT_INDEX_W+IDX_W-1:0] tgt_ext;
    logic              is_store;

    // Latch the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    // Home slot: key mod table size.
    generate
        if (IS_POW2) begin : g_mask
            assign base_slot = r_item.key[IDX_W-1:0];
            assign mod_done  = 1'b1;
        end else begin : g_mod
            localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(TABLE_ENTRIES);
            logic [KEY_W-1:0] r_key_sh;
            logic [IDX_W-1:0] r_rem;
            logic [4:0]       r_mod_cnt;
            logic [IDX_W-1:0] n_rem;

            // Fold four key bits into the remainder each cycle, MSB first.
            always_comb begin
                logic [IDX_W:0] u;
                n_rem = r_rem;
                for (int k = 0; k < 4; k++) begin
                    u = {n_rem, r_key_sh[KEY_W-1-k]};
                    if (u >= N_EXT) u = u - N_EXT;
                    n_rem = u[IDX_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mod_cnt <= '0;
                end else if (i_cmd.load) begin
                    r_mod_cnt <= '0;
                end else if (i_cmd.hash && !r_mod_cnt[4]) begin
                    r_mod_cnt <= r_mod_cnt + 5'd1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_key_sh <= i_in_item.key;
                    r_rem    <= '0;
                end else if (i_cmd.hash && !r_mod_cnt[4]) begin
                    r_key_sh <= {r_key_sh[KEY_W-5:0], 4'b0000};
                    r_rem    <= n_rem;
                end
            end

            assign base_slot = r_rem;
            assign mod_done  = r_mod_cnt[4];
        end
    endgenerate

    // Read issue: one slot of the window per cycle.
    assign issue = i_cmd.scan && (r_issue_off < WIN_OFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_off <= '0;
            r_chk_v     <= 1'b0;
        end else if (i_cmd.start) begin
            r_issue_off <= '0;
            r_chk_v     <= 1'b0;
        end else if (i_cmd.scan) begin
            r_chk_v <= issue;
            if (issue) r_issue_off <= r_issue_off + OFF_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_slot <= base_slot;
        end else if (issue) begin
            r_rd_slot  <= (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + IDX_W'(1);
            r_chk_slot <= r_rd_slot;
            r_chk_off  <= r_issue_off;
        end
    end

    // Evaluate the slot whose data returns this cycle.
    assign rd_slot   = t_slot'(rd_data);
    assign key_match = rd_slot.key == r_item.key;
    assign is_store  = r_item.op == OP_STORE;
    assign hit       = key_match && (rd_slot.depth >= r_item.depth);

    always_comb begin
        take_new_worst = (r_chk_off == '0) || (rd_slot.depth < r_worst_depth);
        n_worst_slot   = take_new_worst ? r_chk_slot    : r_worst_slot;
        n_worst_depth  = take_new_worst ? rd_slot.depth : r_worst_depth;
        if (is_store) begin
            stop     = key_match || (rd_slot.key == '0) || (r_chk_off == LAST_OFF);
            n_target = (key_match || (rd_slot.key == '0)) ? r_chk_slot : n_worst_slot;
        end else begin
            stop     = key_match || (rd_slot.depth == '0) || (r_chk_off == LAST_OFF);
            n_target = r_chk_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && r_chk_v) begin
            r_worst_slot  <= n_worst_slot;
            r_worst_depth <= n_worst_depth;
            if (stop) begin
                r_hit    <= !is_store && hit;
                r_target <= n_target;
                r_fnd    <= rd_slot;
            end
        end
    end

    // Clear sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
        end
    end

    // Write port: clear sweep or store.
    assign we      = i_cmd.clear || i_cmd.write;
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_target;
    always_comb begin
        wr_slot       = '0;
        if (!i_cmd.clear) begin
            wr_slot.key   = r_item.key;
            wr_slot.eval  = r_item.eval;
            wr_slot.depth = r_item.depth;
            wr_slot.flag  = r_item.bound_flag;
        end
    end

    dpht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_slot),
        .i_re      (issue),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (rd_data)
    );

    // Output register.
    assign tgt_ext = {{SLOT_INDEX_W{1'b0}}, r_target};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.hit         <= r_hit;
            r_out.slot_index  <= (r_hit || is_store) ? tgt_ext[SLOT_INDEX_W-1:0] : '0;
            r_out.found_eval  <= r_hit ? r_fnd.eval  : '0;
            r_out.found_depth <= r_hit ? r_fnd.depth : '0;
            r_out.found_flag  <= r_hit ? r_fnd.flag  : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_st.clear_last = r_clr_addr == LAST_SLOT;
    assign o_st.mod_done   = mod_done;
    assign o_st.done       = r_chk_v && stop;
    assign o_st.is_store   = is_store;
    assign o_st.out_free   = !r_out_valid || !i_out_stall;

`ifndef ASSERT_OFF
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.write && i_cmd.clear))
        else $error("store write during clear sweep");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_off <= WIN_OFF)
        else $error("read issue ran past the probe window");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while held");

    a_store_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && is_store) |=> !r_out.hit)
        else $error("store reported a hit");
`endif

endmodule

>>> rtl/core/depth_preferred_hash_table.sv
// Sequence per item: hash, window scan, a write on store only, then emit.
// With non-pow2 TABLE_ENTRIES the hash step folds key mod size four bits per cycle.
// Items are handled one at a time; the scan is paced by one slot read per cycle
// from the single-read-port slot memory.
// Reset: synchronous; a clear pass writes zero to all TABLE_ENTRIES slots, one per cycle,
// with input stalled, before the first item is taken.
module depth_preferred_hash_table
    import dpht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int PROBE_WINDOW  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;
    t_dp_st  st;

    // Controller: clear sweep after reset, then hash, scan, optional write, emit.
    dpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Datapath: slot memory, window scan, replacement choice, result register.
    // The result register decouples the output: a new item is taken while
    // the previous result still waits downstream.
    dpht_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PROBE_WINDOW  (PROBE_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> tb/depth_preferred_hash_table_tb.sv
// Self-checking testbench for the depth-preferred hash table: probe and store traffic.
module depth_preferred_hash_table_tb;
    import dpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE   = 4096;
    localparam int WINDOW       = 4;
    localparam int RANDOM_ITEMS = 1600;
    // Quiet tail: no idling on either side once fewer than this many items remain.
    localparam int QUIET_TAIL   = 120;
    // Long receiver hold-off, started once this many items went in.
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 400;
    // Drain after the last result: worst item time plus margin.
    localparam int DRAIN_CYCLES = 60;
    // Covers the clear pass after reset and the long hold-off.
    localparam int STALL_LIMIT  = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      rx_stall;
    logic      hold_off;
    wire       out_stall = rx_stall || hold_off;

    // Pending items for the driver, and results still owed by the block.
    t_in_item  requests[$];
    t_out_item answers_due[$];

    // Shadow copy of the table; bit arrays start at zero like the cleared RAM.
    bit [KEY_W-1:0]   tt_key  [TABLE_SIZE];
    bit [EVAL_W-1:0]  tt_eval [TABLE_SIZE];
    bit [DEPTH_W-1:0] tt_depth[TABLE_SIZE];
    bit [FLAG_W-1:0]  tt_flag [TABLE_SIZE];

    logic        in_taken;
    logic        quiet;
    int unsigned items_in;
    int unsigned cycle_count;
    int unsigned idle_count;
    int unsigned mismatches;
    int unsigned tx_left;
    int unsigned rx_left;
    int unsigned hold_count;
    logic        hold_done;

    depth_preferred_hash_table #(
        .TABLE_ENTRIES(TABLE_SIZE),
        .PROBE_WINDOW (WINDOW)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Slot at offset within the probe window, wrapping around the table.
    function automatic int unsigned window_slot(logic [KEY_W-1:0] key, int unsigned offset);
        return 32'((key % TABLE_SIZE + offset) % TABLE_SIZE);
    endfunction

    // Apply one item to the shadow table and return the result it must produce.
    function automatic t_out_item probe_or_store(t_in_item item);
        t_out_item   res;
        int unsigned slot;
        int unsigned target;
        int unsigned worst;
        bit          found;
        res = '0;
        if (item.op == OP_PROBE) begin
            for (int i = 0; i < WINDOW; i++) begin
                slot = window_slot(item.key, i);
                // Key compare comes first, so key zero at depth zero hits an empty slot.
                if (tt_key[slot] == item.key) begin
                    if (tt_depth[slot] >= item.depth) begin
                        res.hit         = 1'b1;
                        res.slot_index  = slot[SLOT_INDEX_W-1:0];
                        res.found_eval  = tt_eval[slot];
                        res.found_depth = tt_depth[slot];
                        res.found_flag  = tt_flag[slot];
                    end
                    return res;
                end
                // A zero-depth slot ends the search.
                if (tt_depth[slot] == 0)
                    return res;
            end
            return res;
        end
        target = window_slot(item.key, 0);
        worst  = target;
        found  = 1'b0;
        for (int i = 0; i < WINDOW; i++) begin
            slot = window_slot(item.key, i);
            if (tt_key[slot] == item.key || tt_key[slot] == 0) begin
                target = slot;
                found  = 1'b1;
                break;
            end
            // Strict less-than keeps the earliest slot on ties.
            if (tt_depth[slot] < tt_depth[worst])
                worst = slot;
        end
        if (!found)
            target = worst;
        tt_key[target]   = item.key;
        tt_eval[target]  = item.eval;
        tt_depth[target] = item.depth;
        tt_flag[target]  = item.bound_flag;
        res.slot_index   = target[SLOT_INDEX_W-1:0];
        return res;
    endfunction

    function automatic t_in_item make_item(logic op, logic [KEY_W-1:0] key,
                                           logic [DEPTH_W-1:0] depth,
                                           logic [EVAL_W-1:0] eval,
                                           logic [FLAG_W-1:0] flag);
        t_in_item item;
        item.op         = op;
        item.key        = key;
        item.depth      = depth;
        item.eval       = eval;
        item.bound_flag = flag;
        return item;
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        logic [51:0]        tag_pool[6];
        logic [11:0]        bucket_pool[6];
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
        logic               op;
        int unsigned        pick;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;

        // Directed part. Empty table: key zero at depth zero hits slot zero,
        // depth one turns it into a shallow miss, any other key stops at an empty slot.
        requests.push_back(make_item(OP_PROBE, 64'h0, 8'd0, 32'd0, 8'h00));
        requests.push_back(make_item(OP_PROBE, 64'h0, 8'd1, 32'd0, 8'h00));
        requests.push_back(make_item(OP_PROBE, 64'hDEAD_BEEF_0000_0123, 8'd5, 32'd0, 8'h00));
        // Fill the window of bucket 0x100, then hit, miss shallow, and replace.
        requests.push_back(make_item(OP_STORE, 64'h1111_0000_0000_0100, 8'd10,
                                     32'h7FFF_FFFF, 8'hFF));
        requests.push_back(make_item(OP_PROBE, 64'h1111_0000_0000_0100, 8'd10, 32'd0, 8'h00));
        requests.push_back(make_item(OP_PROBE, 64'h1111_0000_0000_0100, 8'd11, 32'd0, 8'h00));
        requests.push_back(make_item(OP_STORE, 64'h2222_0000_0000_0100, 8'd3,
                                     32'h8000_0000, 8'h00));
        requests.push_back(make_item(OP_STORE, 64'h3333_0000_0000_0100, 8'd3,
                                     32'hFFFF_FFFF, 8'h5A));
        requests.push_back(make_item(OP_STORE, 64'h4444_0000_0000_0100, 8'd255,
                                     32'd17, 8'hA5));
        // Window full: least depth wins, earliest slot on the tie.
        requests.push_back(make_item(OP_STORE, 64'h5555_0000_0000_0100, 8'd1, 32'd1, 8'h01));
        requests.push_back(make_item(OP_STORE, 64'h6666_0000_0000_0100, 8'd7, 32'd2, 8'h02));
        // Evicted key: search runs the whole window and misses; a key still held hits.
        requests.push_back(make_item(OP_PROBE, 64'h2222_0000_0000_0100, 8'd0, 32'd0, 8'h00));
        requests.push_back(make_item(OP_PROBE, 64'h3333_0000_0000_0100, 8'd0, 32'd0, 8'h00));
        // Same key again updates in place.
        requests.push_back(make_item(OP_STORE, 64'h1111_0000_0000_0100, 8'd20, 32'd0, 8'h80));
        // Last bucket: window wraps to slot zero.
        requests.push_back(make_item(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255,
                                     32'h7FFF_FFFF, 8'hFF));
        requests.push_back(make_item(OP_STORE, 64'h8000_0000_0000_0FFF, 8'd2, 32'd9, 8'h33));
        requests.push_back(make_item(OP_PROBE, 64'h8000_0000_0000_0FFF, 8'd2, 32'd0, 8'h00));
        // Key zero is storable and found past an occupied slot.
        requests.push_back(make_item(OP_STORE, 64'h0, 8'd0, 32'd5, 8'h44));
        requests.push_back(make_item(OP_PROBE, 64'h0, 8'd0, 32'd0, 8'h00));
        // Zero-depth entry under a real key stops a probe for a different key.
        requests.push_back(make_item(OP_STORE, 64'h4000_0000_0000_0005, 8'd0,
                                     32'hFFFF_FFFB, 8'h01));
        requests.push_back(make_item(OP_PROBE, 64'h7777_0000_0000_0005, 8'd0, 32'd0, 8'h00));
        requests.push_back(make_item(OP_PROBE, 64'h4000_0000_0000_0005, 8'd0, 32'd0, 8'h00));
        requests.push_back(make_item(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 32'd0, 8'h00));
        requests.push_back(make_item(OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 32'd0, 8'h00));

        // Random part: mostly keys from a small pool so that buckets collide,
        // probes hit and stores evict; the rest are fully random keys and zero.
        foreach (tag_pool[i])
            tag_pool[i] = 52'({$urandom, $urandom});
        bucket_pool = '{12'h000, 12'h001, 12'h100, 12'hFFE, 12'hFFF, 12'h7A3};
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                key = {tag_pool[$urandom_range(0, 5)],
                       12'(bucket_pool[$urandom_range(0, 5)] + $urandom_range(0, 3))};
            else if (pick < 95)
                key = {$urandom, $urandom};
            else
                key = '0;
            depth = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 12));
            op    = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_PROBE;
            requests.push_back(make_item(op, key, depth, $urandom, 8'($urandom_range(0, 255))));
        end

        // Hold reset, release at a falling edge.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last item to go in, then for every result, then drain.
        while (requests.size() != 0 || in_valid)
            @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Driver: advance on acceptance, insert random gaps, hold payload while stalled.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (tx_left != 0) begin
                in_valid <= 1'b0;
                tx_left  <= tx_left - 1;
            end else if (!quiet && cycle_count[9:8] != 2'b11 && $urandom_range(0, 99) < 10) begin
                in_valid <= 1'b0;
                tx_left  <= $urandom_range(0, 15);
            end else if (requests.size() != 0) begin
                in_valid <= 1'b1;
                in_item  <= requests.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, none during calm stretches or the quiet tail.
    always @(negedge clk) begin
        if (!rst_n || quiet || cycle_count[9:8] == 2'b01) begin
            rx_stall <= 1'b0;
            rx_left  <= 0;
        end else if (rx_left != 0) begin
            rx_stall <= 1'b1;
            rx_left  <= rx_left - 1;
        end else if ($urandom_range(0, 99) < 8) begin
            rx_stall <= 1'b1;
            rx_left  <= $urandom_range(0, 15);
        end else begin
            rx_stall <= 1'b0;
        end
    end

    // One long hold-off on the result side so the block backs up into its input.
    always @(negedge clk) begin
        if (!rst_n) begin
            hold_off   <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (hold_off) begin
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_count <= hold_count + 1;
        end else if (!hold_done && items_in >= HOLD_AFTER) begin
            hold_off <= 1'b1;
        end
    end

    // Monitor: predict on each accepted item, check each accepted result.
    always @(posedge clk) begin
        t_out_item want;
        cycle_count <= cycle_count + 1;
        quiet       <= (requests.size() < QUIET_TAIL);
        in_taken    <= in_valid && !in_stall;
        if (in_valid && !in_stall) begin
            answers_due.push_back(probe_or_store(in_item));
            items_in <= items_in + 1;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (answers_due.size() == 0) begin
                $error("result with none expected: %p", out_item);
                mismatches <= mismatches + 1;
            end else begin
                want = answers_due.pop_front();
                if (out_item.hit !== want.hit)
                    $error("hit: expected %0d, actual %0d", want.hit, out_item.hit);
                if (out_item.slot_index !== want.slot_index)
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot_index, out_item.slot_index);
                if (out_item.found_eval !== want.found_eval)
                    $error("found_eval: expected %0d, actual %0d",
                           want.found_eval, out_item.found_eval);
                if (out_item.found_depth !== want.found_depth)
                    $error("found_depth: expected %0d, actual %0d",
                           want.found_depth, out_item.found_depth);
                if (out_item.found_flag !== want.found_flag)
                    $error("found_flag: expected %0d, actual %0d",
                           want.found_flag, out_item.found_flag);
                if (out_item !== want)
                    mismatches <= mismatches + 1;
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (rst_n && out_valid && !out_stall)) begin
            idle_count <= 0;
        end else if (idle_count == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        in_taken    = 1'b0;
        quiet       = 1'b0;
        items_in    = 0;
        cycle_count = 0;
        idle_count  = 0;
        mismatches  = 0;
        tx_left     = 0;
        rx_left     = 0;
        rx_stall    = 1'b0;
        hold_off    = 1'b0;
        hold_count  = 0;
        hold_done   = 1'b0;
    end

endmodule

>>> files.f
rtl/core/dpht_pkg.sv
rtl/core/dpht_ram.sv
rtl/core/dpht_ctrl.sv
rtl/core/dpht_datapath.sv
rtl/core/depth_preferred_hash_table.sv
tb/depth_preferred_hash_table_tb.sv
